### design/kstoa_pkg.sv
// shared types, constants and the character rom for the scancode to ascii buffer
// no dependencies; imported by every module of the block
`default_nettype none

package kstoa_pkg;

   // scancodes with a fixed role
   localparam logic [7:0] KEY_ESC    = 8'h01;
   localparam logic [7:0] KEY_CTRL   = 8'h1D;
   localparam logic [7:0] KEY_LSHIFT = 8'h2A;
   localparam logic [7:0] KEY_RSHIFT = 8'h36;
   localparam logic [7:0] KEY_ALT    = 8'h38;
   localparam logic [7:0] KEY_CAPS   = 8'h3A;
   localparam logic [7:0] REL_BIT    = 8'h80;
   localparam logic [7:0] MAX_MAKE   = 8'h7F;
   localparam logic [7:0] ROM_KEYS   = 8'd58;

   localparam logic [6:0] CHAR_LOW_A = 7'h61;
   localparam logic [6:0] CHAR_LOW_Z = 7'h7A;
   localparam logic [6:0] CHAR_LOW_S = 7'h73;

   // field widths of the channels
   localparam int CHAR_W  = 7;
   localparam int COUNT_W = 5;
   localparam int CODE_W  = 8;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // input item operation
   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // result kind
   typedef enum logic [1:0] {
      RSP_CHAR = 2'd0,
      RSP_DONE = 2'd1,
      RSP_SNAP = 2'd2
   } rsp_kind_type;

   // command kind handed from front to back
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_SNAP  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_kind_type;

   // one queued command; arg is the character or the read limit
   typedef struct packed {
      cmd_kind_type      kind;
      logic [CODE_W-1:0] arg;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FETCH = 2'd1,
      BK_EMIT  = 2'd2
   } back_state_type;

   // one rom row: unshifted and shifted character
   typedef struct packed {
      logic [CHAR_W-1:0] lo;
      logic [CHAR_W-1:0] hi;
   } rom_entry_type;

   // set-1 make code to character, zero where the key has no character
   function automatic rom_entry_type char_rom(input logic [5:0] code);
      rom_entry_type e;
      case (code)
         6'd2:  e = '{7'h31, 7'h21};
         6'd3:  e = '{7'h32, 7'h40};
         6'd4:  e = '{7'h33, 7'h23};
         6'd5:  e = '{7'h34, 7'h24};
         6'd6:  e = '{7'h35, 7'h25};
         6'd7:  e = '{7'h36, 7'h5E};
         6'd8:  e = '{7'h37, 7'h26};
         6'd9:  e = '{7'h38, 7'h2A};
         6'd10: e = '{7'h39, 7'h28};
         6'd11: e = '{7'h30, 7'h29};
         6'd12: e = '{7'h2D, 7'h5F};
         6'd13: e = '{7'h3D, 7'h2B};
         6'd14: e = '{7'h08, 7'h08};
         6'd15: e = '{7'h09, 7'h09};
         6'd16: e = '{7'h71, 7'h51};
         6'd17: e = '{7'h77, 7'h57};
         6'd18: e = '{7'h65, 7'h45};
         6'd19: e = '{7'h72, 7'h52};
         6'd20: e = '{7'h74, 7'h54};
         6'd21: e = '{7'h79, 7'h59};
         6'd22: e = '{7'h75, 7'h55};
         6'd23: e = '{7'h69, 7'h49};
         6'd24: e = '{7'h6F, 7'h4F};
         6'd25: e = '{7'h70, 7'h50};
         6'd26: e = '{7'h5B, 7'h7B};
         6'd27: e = '{7'h5D, 7'h7D};
         6'd28: e = '{7'h0A, 7'h0A};
         6'd30: e = '{7'h61, 7'h41};
         6'd31: e = '{7'h73, 7'h53};
         6'd32: e = '{7'h64, 7'h44};
         6'd33: e = '{7'h66, 7'h46};
         6'd34: e = '{7'h67, 7'h47};
         6'd35: e = '{7'h68, 7'h48};
         6'd36: e = '{7'h6A, 7'h4A};
         6'd37: e = '{7'h6B, 7'h4B};
         6'd38: e = '{7'h6C, 7'h4C};
         6'd39: e = '{7'h3B, 7'h3A};
         6'd40: e = '{7'h27, 7'h22};
         6'd41: e = '{7'h60, 7'h7E};
         6'd43: e = '{7'h5C, 7'h7C};
         6'd44: e = '{7'h7A, 7'h5A};
         6'd45: e = '{7'h78, 7'h58};
         6'd46: e = '{7'h63, 7'h43};
         6'd47: e = '{7'h76, 7'h56};
         6'd48: e = '{7'h62, 7'h42};
         6'd49: e = '{7'h6E, 7'h4E};
         6'd50: e = '{7'h6D, 7'h4D};
         6'd51: e = '{7'h2C, 7'h3C};
         6'd52: e = '{7'h2E, 7'h3E};
         6'd53: e = '{7'h2F, 7'h3F};
         6'd57: e = '{7'h20, 7'h20};
         default: e = '{7'h00, 7'h00};
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### design/kstoa_front.sv
// front end: accepts items, tracks modifier keys, maps scancodes to commands
// depends on kstoa_pkg
`default_nettype none

module kstoa_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [15:0]               req_tdata,   // key_code[7:0], read_limit[15:8]
   input  wire logic                      req_tuser,   // operation
   input  wire logic                      q_full,
   output logic                           q_push,
   output kstoa_pkg::cmd_type             q_cmd
);
   import kstoa_pkg::*;

   logic              shift_ff, shift_in;
   logic              caps_ff, caps_in;
   logic              ctrl_ff, ctrl_in;
   logic              accept;
   logic [CODE_W-1:0] code;
   logic [CODE_W-1:0] limit;
   logic              is_mod;
   logic              has_char;
   rom_entry_type     entry;
   logic              col;
   logic [CHAR_W-1:0] ch;

   assign code       = req_tdata[7:0];
   assign limit      = req_tdata[15:8];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // modifier flag updates
   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      ctrl_in  = ctrl_ff;
      if (accept && (op_type'(req_tuser) == OP_SCAN)) begin
         if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_in = 1'b1;
         end else if (code == (KEY_LSHIFT | REL_BIT) || code == (KEY_RSHIFT | REL_BIT)) begin
            shift_in = 1'b0;
         end else if (code == KEY_CAPS) begin
            caps_in = !caps_ff;
         end else if (code == KEY_CTRL) begin
            ctrl_in = 1'b1;
         end else if (code == (KEY_CTRL | REL_BIT)) begin
            ctrl_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
         ctrl_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
         ctrl_ff  <= ctrl_in;
      end
   end

   // character lookup; caps swaps the column for letters only
   always_comb begin
      is_mod = (code == KEY_ESC) || (code == KEY_CTRL) || (code == KEY_LSHIFT) ||
               (code == KEY_RSHIFT) || (code == KEY_ALT) || (code == KEY_CAPS);
      has_char = (code <= MAX_MAKE) && (code < ROM_KEYS) && !is_mod;
      entry = char_rom(code[5:0]);
      col = shift_ff ^ (caps_ff && (entry.lo >= CHAR_LOW_A) && (entry.lo <= CHAR_LOW_Z));
      ch = col ? entry.hi : entry.lo;
   end

   // command to the back end
   always_comb begin
      q_push   = 1'b0;
      q_cmd.kind = CMD_WRITE;
      q_cmd.arg  = {1'b0, ch};
      if (accept) begin
         if (op_type'(req_tuser) == OP_READ) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_READ;
            q_cmd.arg  = limit;
         end else if (has_char) begin
            if (ctrl_ff) begin
               q_push     = (ch == CHAR_LOW_S);
               q_cmd.kind = CMD_SNAP;
            end else begin
               q_push = (ch != '0);
            end
         end
      end
   end

endmodule

`default_nettype wire

### design/kstoa_queue.sv
// short command queue that decouples the front end from the back end
// depends on kstoa_pkg
`default_nettype none

module kstoa_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire kstoa_pkg::cmd_type   push_cmd,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output kstoa_pkg::cmd_type        head_cmd
);
   import kstoa_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = slot_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count
   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### design/kstoa_back.sv
// back end: character ring, read sequencer and the result output register
// depends on kstoa_pkg
`default_nettype none

module kstoa_back #(
   parameter int RING_DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_not_empty,
   input  wire kstoa_pkg::cmd_type   q_cmd,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // char_code[6:0], count[11:7]
   output logic [1:0]                rsp_tuser,   // kind
   output logic                      rsp_tlast    // last
);
   import kstoa_pkg::*;

   localparam int PW    = $clog2(RING_DEPTH);
   localparam int NW    = $clog2(RING_DEPTH + 1);
   localparam int LW    = (NW > CODE_W) ? NW : CODE_W;
   localparam int CW    = (NW > COUNT_W) ? NW : COUNT_W;

   back_state_type    state_ff, state_in;
   logic [CHAR_W-1:0] ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] full_ff, full_in;
   logic [PW-1:0]     wr_pos_ff, wr_pos_in;
   logic [PW-1:0]     rd_pos_ff, rd_pos_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [CODE_W-1:0] limit_ff, limit_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rd_full_ff;
   logic              wr_en;
   logic              more;
   logic              out_free;
   logic [CW-1:0]     n_wide;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign n_wide   = CW'(n_ff);
   assign more     = rd_full_ff && (LW'(n_ff) != LW'(limit_ff)) &&
                     (n_ff != NW'(RING_DEPTH));

   // sequencer: writes, snapshot results and the read drain
   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      full_in      = full_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_not_empty) begin
               case (q_cmd.kind)
                  CMD_WRITE: begin
                     q_pop              = 1'b1;
                     wr_en              = 1'b1;
                     full_in[wr_pos_ff] = 1'b1;
                     wr_pos_in = (wr_pos_ff == PW'(RING_DEPTH - 1)) ? '0 : wr_pos_ff + 1'b1;
                  end
                  CMD_SNAP: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = RSP_SNAP;
                        rsp_char_in  = '0;
                        rsp_count_in = '0;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     q_pop    = 1'b1;
                     limit_in = q_cmd.arg;
                     n_in     = '0;
                     state_in = BK_FETCH;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_FETCH: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (more) begin
                  rsp_kind_in        = RSP_CHAR;
                  rsp_char_in        = rd_data_ff;
                  rsp_count_in       = '0;
                  rsp_last_in        = 1'b0;
                  full_in[rd_pos_ff] = 1'b0;
                  rd_pos_in = (rd_pos_ff == PW'(RING_DEPTH - 1)) ? '0 : rd_pos_ff + 1'b1;
                  n_in      = n_ff + 1'b1;
                  state_in  = BK_FETCH;
               end else begin
                  rsp_kind_in  = RSP_DONE;
                  rsp_char_in  = '0;
                  rsp_count_in = n_wide[COUNT_W-1:0];
                  rsp_last_in  = 1'b1;
                  state_in     = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers; occupied flags clear the ring at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= '0;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         full_ff      <= full_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      limit_ff     <= limit_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ring memory, registered read at the read position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_pos_ff] <= q_cmd.arg[CHAR_W-1:0];
      end
      rd_data_ff <= ring_mem[rd_pos_ff];
      rd_full_ff <= full_ff[rd_pos_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {4'b0, rsp_count_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### design/keyboard_scancode_to_ascii_buffer.sv
// top level of the scancode to ascii buffer: front end, command queue, back end
// depends on kstoa_pkg, kstoa_front, kstoa_queue, kstoa_back
// Usage:
//   req channel carries either a set-1 scancode (req_tuser = 0) or a read
//   request (req_tuser = 1) with the most characters to take in read_limit.
//   rsp channel returns kind in rsp_tuser: a character, a read finished with
//   the count delivered, or a snapshot request when ctrl+s is pressed;
//   rsp_tlast marks the final result caused by one input item.
// Timing:
//   the front end takes one item per cycle into a four-entry command queue;
//   req_tready drops only while that queue is full.
//   the back end handles a ring write or a snapshot straight from idle; a read
//   alternates a registered ring read (fetch) and the output of one character
//   (emit), then outputs the finished result, taking no other command meanwhile.
//   with the back end idle, a snapshot result is registered in the command
//   queue and then the result register; a read also passes fetch and emit.
// Reset: synchronous; clears modifier flags, ring positions, the queue and all
//   ring occupied flags, so the ring reads as empty at once.
// Stall: a low rsp_tready holds the result register; the back end waits at its
//   next snapshot or read result, the queue fills and then req_tready goes low.
`default_nettype none

module keyboard_scancode_to_ascii_buffer #(
   parameter int RING_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // key_code[7:0], read_limit[15:8]
   input  wire logic        req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // char_code[6:0], count[11:7], zero fill
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast    // last
);
   import kstoa_pkg::*;

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // classify incoming items
   kstoa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // decoupling queue
   kstoa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // ring and result generation
   kstoa_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

### design/kstoa_checker.sv
// port-level checks on the result channel of the scancode to ascii buffer
// depends on kstoa_pkg; bound to keyboard_scancode_to_ascii_buffer
`default_nettype none

module kstoa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import kstoa_pkg::*;

   // a stalled result transfer holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // characters never close an item, every other kind does
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != RSP_CHAR)))
      else $error("last flag does not match result kind");

   // a delivered character is never an empty ring entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == RSP_CHAR) |-> (rsp_tdata[6:0] != '0) &&
      (rsp_tdata[11:7] == '0))
      else $error("character result with empty code or count");

   // snapshot and finished results carry no character, snapshot no count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != RSP_CHAR) |-> (rsp_tdata[6:0] == '0) &&
      ((rsp_tuser == RSP_DONE) || (rsp_tdata[11:7] == '0)))
      else $error("non-character result carries character or count");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind keyboard_scancode_to_ascii_buffer kstoa_checker u_kstoa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### test/tb.sv
// testbench for keyboard_scancode_to_ascii_buffer: directed and random scancodes and reads
// depends on kstoa_pkg and the design sources; self-checking through a result scoreboard
`timescale 1ns / 1ps

module tb;
   import kstoa_pkg::*;

   localparam int DEPTH     = 16;
   localparam int RAND_ITEMS = 335;

   // one expected result of the block
   typedef struct {
      rsp_kind_type kind;
      logic [6:0]   char_code;
      logic [4:0]   count;
      logic         last;
   } key_result_type;

   // predicts the character ring and checks results in order
   class ascii_scoreboard;
      logic [6:0]  lo_tab [0:57];
      logic [6:0]  hi_tab [0:57];
      logic [6:0]  ring [0:DEPTH-1];
      int          wr_pos;
      int          rd_pos;
      bit          shift_on;
      bit          caps_on;
      bit          ctrl_on;
      key_result_type pending_results [$];
      int          errors;
      int          chars_checked;
      int          reads_checked;
      int          snaps_checked;

      function new();
         for (int i = 0; i < 58; i++) begin
            lo_tab[i] = '0;
            hi_tab[i] = '0;
         end
         for (int i = 0; i < DEPTH; i++) ring[i] = '0;
         // character rows of the keyboard
         put_row(2, "1234567890-=", "!@#$%^&*()_+");
         put_row(16, "qwertyuiop[]", "QWERTYUIOP{}");
         put_row(30, "asdfghjkl;'", "ASDFGHJKL:\"");
         put_row(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
         put_row(57, " ", " ");
         // control characters and the backtick key
         lo_tab[14] = 7'h08;  hi_tab[14] = 7'h08;
         lo_tab[15] = 7'h09;  hi_tab[15] = 7'h09;
         lo_tab[28] = 7'h0A;  hi_tab[28] = 7'h0A;
         lo_tab[41] = 7'h60;  hi_tab[41] = 7'h7E;
         wr_pos = 0;
         rd_pos = 0;
         shift_on = 0;
         caps_on = 0;
         ctrl_on = 0;
         errors = 0;
         chars_checked = 0;
         reads_checked = 0;
         snaps_checked = 0;
      endfunction

      function void put_row(int first, string lo, string hi);
         for (int i = 0; i < lo.len(); i++) begin
            lo_tab[first + i] = 7'(lo[i]);
            hi_tab[first + i] = 7'(hi[i]);
         end
      endfunction

      function void push_result(rsp_kind_type kind, logic [6:0] ch, logic [4:0] cnt,
                                logic last);
         key_result_type r;
         r.kind = kind;
         r.char_code = ch;
         r.count = cnt;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      // one accepted input transfer: update state, queue what it causes
      function void accept_item(op_type op, logic [7:0] code, logic [7:0] limit);
         int         n;
         bit         col;
         logic [6:0] base;
         logic [6:0] ch;
         if (op == OP_READ) begin
            n = 0;
            while (n < limit && n < DEPTH && ring[rd_pos] != 0) begin
               push_result(RSP_CHAR, ring[rd_pos], '0, 1'b0);
               ring[rd_pos] = '0;
               rd_pos = (rd_pos + 1) % DEPTH;
               n++;
            end
            push_result(RSP_DONE, '0, n[4:0], 1'b1);
            return;
         end
         // modifier flags
         if (code == KEY_LSHIFT || code == KEY_RSHIFT)
            shift_on = 1;
         else if (code == (KEY_LSHIFT | REL_BIT) || code == (KEY_RSHIFT | REL_BIT))
            shift_on = 0;
         else if (code == KEY_CAPS)
            caps_on = !caps_on;
         else if (code == KEY_CTRL)
            ctrl_on = 1;
         else if (code == (KEY_CTRL | REL_BIT))
            ctrl_on = 0;
         if (code >= ROM_KEYS || code == KEY_ESC || code == KEY_CTRL ||
             code == KEY_LSHIFT || code == KEY_RSHIFT || code == KEY_ALT)
            return;
         // caps swaps the column for letters only
         col = shift_on;
         base = lo_tab[code];
         if (caps_on && base >= CHAR_LOW_A && base <= CHAR_LOW_Z) col = !col;
         ch = col ? hi_tab[code] : lo_tab[code];
         if (ctrl_on) begin
            if (ch == CHAR_LOW_S) push_result(RSP_SNAP, '0, '0, 1'b1);
            return;
         end
         if (ch == 0) return;
         ring[wr_pos] = ch;
         wr_pos = (wr_pos + 1) % DEPTH;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endtask

      // one accepted result transfer against the oldest expectation
      task check_result(rsp_kind_type kind, logic [6:0] ch, logic [4:0] cnt, logic last);
         key_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d char %02h count %0d last %0d",
                             kind, ch, cnt, last));
            return;
         end
         want = pending_results.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind got %0d want %0d", kind, want.kind));
         if (ch !== want.char_code)
            report($sformatf("char_code got %02h want %02h", ch, want.char_code));
         if (cnt !== want.count)
            report($sformatf("count got %0d want %0d", cnt, want.count));
         if (last !== want.last)
            report($sformatf("last got %0d want %0d", last, want.last));
         case (want.kind)
            RSP_CHAR: chars_checked++;
            RSP_DONE: reads_checked++;
            default:  snaps_checked++;
         endcase
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // key_code[7:0], read_limit[15:8]
   logic        req_tuser = 1'b0;  // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // char_code[6:0], count[11:7], zero fill
   logic [1:0]  rsp_tuser;         // kind
   logic        rsp_tlast;

   ascii_scoreboard sb = new();
   int              req_idle_pct = 36;
   int              rsp_stall_pct = 36;
   int              items_sent = 0;

   keyboard_scancode_to_ascii_buffer #(.RING_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // drive one input transfer, with random idle cycles ahead of it
   task send_item(op_type op, logic [7:0] code, logic [7:0] limit);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {limit, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.accept_item(op, code, limit);
      items_sent++;
   endtask

   task send_scan(logic [7:0] code);
      send_item(OP_SCAN, code, 8'($urandom_range(255)));
   endtask

   task send_read(logic [7:0] limit);
      send_item(OP_READ, 8'($urandom_range(255)), limit);
   endtask

   // hold the input side until every expected result has come back
   task wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver back-pressure
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_kind_type'(rsp_tuser), rsp_tdata[6:0], rsp_tdata[11:7],
                         rsp_tlast);
   end

   // run limit
   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   // stimulus
   initial begin
      int pick;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty read, rom gap, shift, caps, ctrl chords, ignored codes
      send_read(8'd255);
      send_scan(8'h00);
      send_scan(8'h10);
      send_scan(KEY_LSHIFT);
      send_scan(8'h1E);
      send_scan(8'h02);
      send_scan(KEY_LSHIFT | REL_BIT);
      send_scan(KEY_CAPS);
      send_scan(8'h1E);
      send_scan(8'h02);
      send_scan(KEY_RSHIFT);
      send_scan(8'h2C);
      send_scan(KEY_RSHIFT | REL_BIT);
      send_scan(KEY_CAPS);
      send_scan(KEY_CTRL);
      send_scan(8'h1F);
      send_scan(8'h1E);
      send_scan(KEY_CTRL | REL_BIT);
      send_scan(KEY_ESC);
      send_scan(KEY_ALT);
      send_scan(MAX_MAKE);
      send_scan(8'hFF);
      send_read(8'd0);
      send_read(8'd2);
      send_read(8'd255);

      // random: mostly typing, with reads, modifier changes, ctrl chords and noise
      for (int i = 0; i < RAND_ITEMS; i++) begin
         // a long stretch without idling on either side
         if (i == 100) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         if (i == 180) begin
            req_idle_pct = 36;
            rsp_stall_pct = 36;
         end
         if (i == 220) wait_drained();
         pick = $urandom_range(99);
         if (pick < 12) begin
            if ($urandom_range(1)) send_read(8'($urandom_range(20)));
            else if ($urandom_range(3) == 0) send_read(8'd255);
            else send_read(8'($urandom_range(255)));
         end else if (pick < 18) begin
            case ($urandom_range(4))
               0: send_scan(KEY_LSHIFT);
               1: send_scan(KEY_RSHIFT);
               2: send_scan(KEY_LSHIFT | REL_BIT);
               3: send_scan(KEY_RSHIFT | REL_BIT);
               default: send_scan(KEY_CAPS);
            endcase
         end else if (pick < 22) begin
            send_scan(KEY_CTRL);
            if ($urandom_range(1)) send_scan(8'h1F);
            else send_scan(8'($urandom_range(57)));
            send_scan(KEY_CTRL | REL_BIT);
         end else if (pick < 30) begin
            send_scan(8'($urandom_range(255)));
         end else begin
            send_scan(8'($urandom_range(57)));
         end
      end

      // drain and let the block settle
      wait_drained();
      repeat (40) @(posedge clock);

      $display("run covered %0d input transfers: %0d characters, %0d reads, %0d snapshots",
               items_sent, sb.chars_checked, sb.reads_checked, sb.snaps_checked);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
